FILE: sv/tpwb_pkg.sv
// ----------------------------------------------------------------------------
// tpwb_pkg
// Shared types and constants for the tuner PLL word builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpwb_pkg;

  // Register map (word index, byte address = 4 * index)
  localparam logic [1:0] REG_TUNER_TYPE = 2'd0;
  localparam logic [1:0] REG_TV_NORM    = 2'd1;
  localparam logic [1:0] REG_CARD_KIND  = 2'd2;
  localparam logic [1:0] REG_BOARD_REV  = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // TV norm codes of interest
  localparam logic [2:0] NORM_NTSC    = 3'd1;
  localparam logic [2:0] NORM_SECAM   = 3'd2;
  localparam logic [2:0] NORM_NTSC_J  = 3'd4;
  localparam logic [2:0] NORM_PAL_M   = 3'd6;

  // Card kinds (anything else counts as other)
  localparam logic [1:0] CARD_BUILT_IN   = 2'd0;
  localparam logic [1:0] CARD_STANDALONE = 2'd1;
  localparam logic [1:0] CARD_OTHER      = 2'd2;

  // IF offsets in 1/100 MHz
  localparam logic [12:0] IF_OFFS_HIGH = 13'd4575;
  localparam logic [12:0] IF_OFFS_LOW  = 13'd3890;

  // Fixed control byte of the tuner word
  localparam logic [7:0] CTRL_BYTE = 8'h8E;

  // Widths of the internal arithmetic
  localparam int unsigned FREQ_W = 19;  // f in 1/100 MHz
  localparam int unsigned DIV_W  = 23;  // divider word D
  localparam int unsigned W_W    = 17;  // D / 100

  // Reciprocals for division by 100: D < 2^23 uses 2^30, f+3 < 2^19 uses 2^26
  localparam logic [23:0] RECIP_D   = 24'd10737419;
  localparam int unsigned RECIP_D_SH = 30;
  localparam logic [19:0] RECIP_T   = 20'd671089;
  localparam int unsigned RECIP_T_SH = 26;

  // Configuration register bank as seen by the datapath
  typedef struct packed {
    logic [4:0] tuner_type;
    logic [2:0] tv_norm;
    logic [1:0] card_kind;
    logic [7:0] board_revision;
  } tpwb_cfg_t;

endpackage

`default_nettype wire

FILE: sv/tpwb_if.sv
// ----------------------------------------------------------------------------
// tpwb_if
// Valid/ready channels for tuning requests and tuner words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpwb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_freq;

  modport source (output valid, output channel_freq, input ready);
  modport sink   (input valid, input channel_freq, output ready);
endinterface

interface tpwb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tuner_byte0;
  logic [7:0]  tuner_byte1;
  logic [7:0]  tuner_byte2;
  logic [7:0]  tuner_byte3;
  logic [11:0] tuned_freq;

  modport source (output valid, output tuner_byte0, output tuner_byte1,
                  output tuner_byte2, output tuner_byte3, output tuned_freq,
                  input ready);
  modport sink   (input valid, input tuner_byte0, input tuner_byte1,
                  input tuner_byte2, input tuner_byte3, input tuned_freq,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/tpwb_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpwb_cfg_regs
// APB-style register bank: tuner type, TV norm, card kind, board revision.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwb_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tpwb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [tpwb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [tpwb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output tpwb_pkg::tpwb_cfg_t                    cfg
);
  import tpwb_pkg::*;

  tpwb_cfg_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tuner_type     <= 5'd0;
      cfg_r.tv_norm        <= NORM_NTSC;
      cfg_r.card_kind      <= CARD_OTHER;
      cfg_r.board_revision <= 8'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TUNER_TYPE: cfg_r.tuner_type     <= pwdata[4:0];
        REG_TV_NORM:    cfg_r.tv_norm        <= pwdata[2:0];
        REG_CARD_KIND:  cfg_r.card_kind      <= pwdata[1:0];
        REG_BOARD_REV:  cfg_r.board_revision <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TUNER_TYPE: prdata = {27'd0, cfg_r.tuner_type};
      REG_TV_NORM:    prdata = {29'd0, cfg_r.tv_norm};
      REG_CARD_KIND:  prdata = {30'd0, cfg_r.card_kind};
      REG_BOARD_REV:  prdata = {24'd0, cfg_r.board_revision};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tpwb_band_lut.sv
// ----------------------------------------------------------------------------
// tpwb_band_lut
// Band-control byte from tuner type, frequency thresholds and board options.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwb_band_lut (
  input  tpwb_pkg::tpwb_cfg_t                 cfg,
  input  wire logic [tpwb_pkg::FREQ_W-1:0]    freq,
  output logic      [7:0]                     band
);
  import tpwb_pkg::*;

  logic [7:0] sys_code;

  // pick among three bands by two upper edges
  function automatic logic [7:0] pick3(input logic [FREQ_W-1:0] f,
                                       input logic [15:0] t0,
                                       input logic [15:0] t1,
                                       input logic [7:0]  b0,
                                       input logic [7:0]  b1,
                                       input logic [7:0]  b2);
    logic [7:0] r;
    if (f <= {3'd0, t0})      r = b0;
    else if (f <= {3'd0, t1}) r = b1;
    else                      r = b2;
    return r;
  endfunction

  // pick among four bands by three upper edges
  function automatic logic [7:0] pick4(input logic [FREQ_W-1:0] f,
                                       input logic [15:0] t0,
                                       input logic [15:0] t1,
                                       input logic [15:0] t2,
                                       input logic [7:0]  b0,
                                       input logic [7:0]  b1,
                                       input logic [7:0]  b2,
                                       input logic [7:0]  b3);
    logic [7:0] r;
    if (f <= {3'd0, t0})      r = b0;
    else if (f <= {3'd0, t1}) r = b1;
    else if (f <= {3'd0, t2}) r = b2;
    else                      r = b3;
    return r;
  endfunction

  // SECAM tuners use a different system nibble
  assign sys_code = (cfg.tv_norm == NORM_SECAM) ? 8'd3 : 8'd1;

  always_comb begin
    band = 8'h00;
    unique case (cfg.tuner_type) inside
      5'd1, 5'd2, 5'd12:
        band = pick4(freq, 16'd16000, 16'd45125, 16'd46325,
                     8'hA2, 8'h94, 8'h34, 8'h31);
      5'd3, 5'd4, 5'd9, 5'd10, 5'd13:
        band = pick4(freq, 16'd14025, 16'd16825, 16'd44725,
                     8'hA2, 8'hA4, 8'h94, 8'h31);
      5'd6:
        band = pick3(freq, 16'd16000, 16'd45400, 8'hA0, 8'h90, 8'h30);
      5'd7:
        band = pick3(freq, 16'd16825, 16'd45525, 8'hA0, 8'h90, 8'h30);
      5'd5, 5'd11:
        band = pick3(freq, 16'd16825, 16'd44725, 8'hA0 + sys_code,
                     8'h90 + sys_code, 8'h30 + sys_code);
      5'd8: begin
        if (cfg.card_kind == CARD_BUILT_IN)
          band = pick3(freq, 16'd16000, 16'd45400, 8'hA0, 8'h90, 8'h30);
        else if (cfg.card_kind == CARD_STANDALONE && cfg.board_revision == 8'd0)
          band = pick4(freq, 16'd15725, 16'd45125, 16'd46325,
                       8'hA2, 8'h94, 8'h34, 8'h31);
        else
          band = pick3(freq, 16'd12725, 16'd36125, 8'h01, 8'h02, 8'h08);
      end
      5'd16, 5'd17, 5'd18:
        band = pick3(freq, 16'd13000, 16'd36400, 8'h14, 8'h12, 8'h11);
      default: band = 8'h00;  // unknown tuner
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tpwb_datapath.sv
// ----------------------------------------------------------------------------
// tpwb_datapath
// Input register, divider and band arithmetic, word ordering, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwb_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tpwb_pkg::tpwb_cfg_t cfg,
  tpwb_in_if.sink            in_ch,
  tpwb_out_if.source         out_ch
);
  import tpwb_pkg::*;

  // stage valids and payload
  logic                s1_v_r, s1_v_nxt;
  logic [15:0]         cf_r;
  logic                out_v_r, out_v_nxt;
  logic [7:0]          byte0_r, byte1_r, byte2_r, byte3_r;
  logic [11:0]         tuned_r;
  logic [DIV_W-1:0]    last_div_r;

  logic                in_acc, s1_adv;

  // arithmetic
  logic [22:0]         cf_x100;
  logic [FREQ_W-1:0]   freq;
  logic [12:0]         offs;
  logic [19:0]         g_sum;
  logic [23:0]         d_full;
  logic [DIV_W-1:0]    div;
  logic [46:0]         w_prod;
  logic [W_W-1:0]      w_quo;
  logic [19:0]         t_sum;
  logic [38:0]         t_prod;
  logic [11:0]         tuned;
  logic [7:0]          band;
  logic [7:0]          hi_byte, lo_byte;
  logic                rises;

  // handshake: stage 1 moves on whenever the result register is free
  assign s1_adv       = s1_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready  = ~s1_v_r | s1_adv;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign s1_v_nxt     = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt    = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  // f = cf * 100 / 16, by shift-and-add
  assign cf_x100 = {1'b0, cf_r, 6'd0} + {2'd0, cf_r, 5'd0} + {5'd0, cf_r, 2'd0};
  assign freq    = cf_x100[22:4];

  // IF offset from the TV norm
  assign offs = (cfg.tv_norm == NORM_NTSC || cfg.tv_norm == NORM_NTSC_J ||
                 cfg.tv_norm == NORM_PAL_M) ? IF_OFFS_HIGH : IF_OFFS_LOW;

  // divider word D = (f + offs) * 16 + 50
  assign g_sum  = {1'b0, freq} + {7'd0, offs};
  assign d_full = {g_sum, 4'd0} + 24'd50;
  assign div    = d_full[DIV_W-1:0];

  // W = D / 100 by reciprocal
  assign w_prod = {24'd0, div} * {23'd0, RECIP_D};
  assign w_quo  = w_prod[RECIP_D_SH +: W_W];
  assign hi_byte = {1'b0, w_quo[14:8]};
  assign lo_byte = w_quo[7:0];

  // tuned frequency = (f + 3) / 100 by reciprocal
  assign t_sum  = {1'b0, freq} + 20'd3;
  assign t_prod = {20'd0, t_sum[FREQ_W-1:0]} * {19'd0, RECIP_T};
  assign tuned  = t_prod[RECIP_T_SH +: 12];

  assign rises = div > last_div_r;

  tpwb_band_lut u_band (
    .cfg  (cfg),
    .freq (freq),
    .band (band)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      last_div_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_adv) last_div_r <= div;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) cf_r <= in_ch.channel_freq;
  end

  // result register: divider bytes first on a rising divider
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tuned_r <= tuned;
      if (rises) begin
        byte0_r <= hi_byte;
        byte1_r <= lo_byte;
        byte2_r <= CTRL_BYTE;
        byte3_r <= band;
      end else begin
        byte0_r <= CTRL_BYTE;
        byte1_r <= band;
        byte2_r <= hi_byte;
        byte3_r <= lo_byte;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.tuner_byte0 = byte0_r;
  assign out_ch.tuner_byte1 = byte1_r;
  assign out_ch.tuner_byte2 = byte2_r;
  assign out_ch.tuner_byte3 = byte3_r;
  assign out_ch.tuned_freq  = tuned_r;

  // checks
  a_last_div: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> last_div_r == $past(div))
    else $error("stored divider not taken from the item just passed on");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r)
    else $error("result register empty after an item was passed on");

  a_rise_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && rises |=> byte2_r == CTRL_BYTE)
    else $error("control byte misplaced for a rising divider");

  a_fall_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !rises |=> byte0_r == CTRL_BYTE)
    else $error("control byte misplaced for a non-rising divider");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled while result register is free");

endmodule

`default_nettype wire

FILE: sv/tuner_pll_word_builder_top.sv
// ----------------------------------------------------------------------------
// tuner_pll_word_builder_top
// Builds the four-byte tuner PLL word and the written-back frequency from a
// channel frequency request.
// ----------------------------------------------------------------------------
// Each request (channel frequency in 1/16 MHz) yields exactly one word of four
// tuner bytes plus the rounded frequency. The block takes one request per
// clock while out_ch.ready does not hold the result register; each result
// passes the input register, then the result register, with the single
// arithmetic stage between them, whose longest path is the 23 x 24 bit
// reciprocal multiply for D / 100. The divider of every request is stored and
// decides the byte order of the next one. Registers sit at byte addresses 0
// (tuner type), 4 (TV norm), 8 (card kind) and 12 (board revision); write them
// only while no request is in flight. Reset: type 0, norm 1, card kind 2,
// revision 0, stored divider 0.
`default_nettype none

module tuner_pll_word_builder_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  tpwb_in_if.sink                               in_ch,
  tpwb_out_if.source                            out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tpwb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tpwb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tpwb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import tpwb_pkg::*;

  tpwb_cfg_t cfg;

  tpwb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpwb_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
